// File: rtl/clrt_pkg.sv
// ----------------------------------------------------------------------------
// clrt_pkg
// Shared types and codes for the circular linked ring table: id widths,
// operation codes and the command and status groups that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package clrt_pkg;

	// Field widths.
	localparam int ID_W   = 12;
	localparam int FUNC_W = 3;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [FUNC_W-1:0] func_t;

	// Operation codes. Codes above remove-prev behave as remove-prev.
	localparam func_t FN_LOAD       = 3'd0;
	localparam func_t FN_INS_AFTER  = 3'd1;
	localparam func_t FN_INS_BEFORE = 3'd2;
	localparam func_t FN_REM_NEXT   = 3'd3;
	localparam func_t FN_REM_PREV   = 3'd4;

	// Input select of the slot reduction unit.
	typedef logic [1:0] slot_sel_t;
	localparam slot_sel_t SL_A    = 2'd0;
	localparam slot_sel_t SL_B    = 2'd1;
	localparam slot_sel_t SL_LINK = 2'd2;

	// Link table write steps.
	typedef logic [2:0] wr_step_t;
	localparam wr_step_t WR_NONE   = 3'd0;
	localparam wr_step_t WR_INIT   = 3'd1;
	localparam wr_step_t WR_FIRST  = 3'd2;
	localparam wr_step_t WR_SECOND = 3'd3;
	localparam wr_step_t WR_REMOVE = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      cap_in;
		slot_sel_t slot_sel;
		logic      rd_en;
		logic      rd_head;
		logic      cap_sa;
		logic      cap_sb;
		logic      cap_nb;
		logic      cap_snb;
		logic      cap_nn;
		logic      cap_snn;
		wr_step_t  wr_step;
		logic      set_head;
		logic      res_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_load;
		logic is_remove;
		logic ring_empty;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/circular_linked_ring_table.sv
// ----------------------------------------------------------------------------
// circular_linked_ring_table
// Circular doubly linked ring of 12-bit ids kept in next and prev link
// memories. Loads append at the tail; commands insert or remove beside a
// reference id and return the displaced or removed neighbour.
//
//   Channel | Direction | Handshake           | Beat payload
//   --------+-----------+---------------------+-------------------------------
//   in      | input     | in_valid / in_ready | func, station, new_station
//   out     | output    | out_valid/out_ready | neighbour
//
// One item at a time; the time an item takes is set by the chain of
// dependent link reads, each through the two-stage id-to-slot reduction
// and the registered memory read port. A first load or a command on an
// empty ring is quickest, then a load, an insert and a removal.
// Reset clears the ring to empty; the link memories need no clearing pass.
// A result waiting in the output register does not block the next input
// beat; only the next result waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_linked_ring_table #(
	parameter int ID_COUNT = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [clrt_pkg::FUNC_W-1:0]   func,
	input  wire logic [clrt_pkg::ID_W-1:0]     station,
	input  wire logic [clrt_pkg::ID_W-1:0]     new_station,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [clrt_pkg::ID_W-1:0]          neighbour
);

	clrt_pkg::cmd_t cmd;
	clrt_pkg::sts_t sts;

	// Sequencer.
	clrt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Link memories and registers.
	clrt_dp #(
		.ID_COUNT(ID_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (func),
		.station    (station),
		.new_station(new_station),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.neighbour  (neighbour)
	);

endmodule

`default_nettype wire

// File: rtl/clrt_slot.sv
// ----------------------------------------------------------------------------
// clrt_slot
// Two-stage reduction of an id to its table slot (id modulo ID_COUNT).
// Stage one multiplies by a scaled reciprocal, stage two subtracts the
// quotient times ID_COUNT. Exact for every 12-bit id.
// ----------------------------------------------------------------------------
`default_nettype none

module clrt_slot #(
	parameter int ID_COUNT = 4096
) (
	input  wire logic                          clk,
	input  wire logic [clrt_pkg::ID_W-1:0]     id,
	output logic [$clog2((ID_COUNT < (1 << clrt_pkg::ID_W)) ? ID_COUNT
	                     : (1 << clrt_pkg::ID_W))-1:0] slot
);

	localparam int ID_W  = clrt_pkg::ID_W;
	localparam int DEPTH = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
	localparam int AW    = $clog2(DEPTH);
	localparam int L     = $clog2(ID_COUNT);
	localparam int S     = ID_W + L;
	localparam longint unsigned TWO_S = 64'd1 << S;
	localparam longint unsigned MULT  = (TWO_S + ID_COUNT - 1) / ID_COUNT;
	localparam int MW    = $clog2(MULT + 1);
	localparam int PW    = ID_W + MW;
	localparam int NW    = $clog2(ID_COUNT + 1);
	localparam int QW    = ID_W + NW;

	logic [ID_W-1:0] id_s1;
	logic [PW-1:0]   prod_s1;
	logic [AW-1:0]   slot_s2;
	logic [ID_W-1:0] quot;
	logic [QW-1:0]   quot_n;
	logic [QW-1:0]   rem;

	// Stage one: scaled reciprocal product.
	always_ff @(posedge clk) begin
		id_s1   <= id;
		prod_s1 <= PW'(id) * PW'(MULT);
	end

	// Stage two: remainder from the quotient.
	assign quot   = ID_W'(prod_s1 >> S);
	assign quot_n = QW'(quot) * QW'(ID_COUNT);
	assign rem    = QW'(id_s1) - quot_n;

	always_ff @(posedge clk) begin
		slot_s2 <= rem[AW-1:0];
	end

	assign slot = slot_s2;

endmodule

`default_nettype wire

// File: rtl/clrt_dp.sv
// ----------------------------------------------------------------------------
// clrt_dp
// Datapath of the ring table: the next and prev link memories, the
// operand and link registers, ring head state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module clrt_dp #(
	parameter int ID_COUNT = 4096
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire clrt_pkg::cmd_t                  cmd,
	output clrt_pkg::sts_t                       sts,
	input  wire logic [clrt_pkg::FUNC_W-1:0]     func,
	input  wire logic [clrt_pkg::ID_W-1:0]       station,
	input  wire logic [clrt_pkg::ID_W-1:0]       new_station,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [clrt_pkg::ID_W-1:0]            neighbour
);

	localparam int ID_W  = clrt_pkg::ID_W;
	localparam int DEPTH = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
	localparam int AW    = $clog2(DEPTH);

	// Link memories.
	clrt_pkg::id_t next_mem [DEPTH];
	clrt_pkg::id_t prev_mem [DEPTH];

	clrt_pkg::func_t func_q;
	clrt_pkg::id_t   a_q, b_q, nb_q, nn_q, head_q;
	logic [AW-1:0]   sa_q, sb_q, snb_q, snn_q, head_slot_q;
	logic            empty_q;
	clrt_pkg::id_t   rd_next_q, rd_prev_q;
	logic            out_valid_q;
	clrt_pkg::id_t   neighbour_q;

	clrt_pkg::id_t   slot_in;
	logic [AW-1:0]   slot_out;
	logic [AW-1:0]   rd_addr;
	clrt_pkg::id_t   link_pick;
	logic            use_next;

	logic            nw_en, pw_en;
	logic [AW-1:0]   nw_addr, pw_addr;
	clrt_pkg::id_t   nw_data, pw_data;

	// Operand capture.
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			func_q <= func;
			a_q    <= station;
			b_q    <= new_station;
		end
	end

	// Insert-after and remove-next follow next links; all else follows prev.
	assign use_next  = (func_q == clrt_pkg::FN_INS_AFTER) ||
	                   (func_q == clrt_pkg::FN_REM_NEXT);
	assign link_pick = use_next ? rd_next_q : rd_prev_q;

	// Slot reduction input select.
	always_comb begin
		unique case (cmd.slot_sel)
			clrt_pkg::SL_A:    slot_in = a_q;
			clrt_pkg::SL_B:    slot_in = b_q;
			clrt_pkg::SL_LINK: slot_in = link_pick;
			default:           slot_in = a_q;
		endcase
	end

	clrt_slot #(
		.ID_COUNT(ID_COUNT)
	) u_slot (
		.clk (clk),
		.id  (slot_in),
		.slot(slot_out)
	);

	// Slot and link registers.
	always_ff @(posedge clk) begin
		if (cmd.cap_sa)  sa_q  <= slot_out;
		if (cmd.cap_sb)  sb_q  <= slot_out;
		if (cmd.cap_snb) snb_q <= slot_out;
		if (cmd.cap_snn) snn_q <= slot_out;
		if (cmd.cap_nb)  nb_q  <= link_pick;
		if (cmd.cap_nn)  nn_q  <= link_pick;
	end

	// Ring head and empty flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q     <= 1'b1;
			head_q      <= '0;
			head_slot_q <= '0;
		end else if (cmd.set_head) begin
			empty_q     <= 1'b0;
			head_q      <= a_q;
			head_slot_q <= sa_q;
		end
	end

	// Write decode: each step writes at most one entry of each table.
	always_comb begin
		nw_en   = 1'b0;
		pw_en   = 1'b0;
		nw_addr = '0;
		pw_addr = '0;
		nw_data = '0;
		pw_data = '0;
		unique case (cmd.wr_step)
			clrt_pkg::WR_INIT: begin
				nw_en = 1'b1; nw_addr = sa_q; nw_data = a_q;
				pw_en = 1'b1; pw_addr = sa_q; pw_data = a_q;
			end
			clrt_pkg::WR_FIRST: begin
				nw_en = 1'b1;
				pw_en = 1'b1;
				priority if (func_q == clrt_pkg::FN_LOAD) begin
					nw_addr = snb_q; nw_data = a_q;
					pw_addr = sa_q;  pw_data = nb_q;
				end else if (func_q == clrt_pkg::FN_INS_AFTER) begin
					nw_addr = sa_q;  nw_data = b_q;
					pw_addr = snb_q; pw_data = b_q;
				end else begin
					pw_addr = sa_q;  pw_data = b_q;
					nw_addr = snb_q; nw_data = b_q;
				end
			end
			clrt_pkg::WR_SECOND: begin
				nw_en = 1'b1;
				pw_en = 1'b1;
				priority if (func_q == clrt_pkg::FN_LOAD) begin
					nw_addr = sa_q;        nw_data = head_q;
					pw_addr = head_slot_q; pw_data = a_q;
				end else if (func_q == clrt_pkg::FN_INS_AFTER) begin
					pw_addr = sb_q; pw_data = a_q;
					nw_addr = sb_q; nw_data = nb_q;
				end else begin
					pw_addr = sb_q; pw_data = nb_q;
					nw_addr = sb_q; nw_data = a_q;
				end
			end
			clrt_pkg::WR_REMOVE: begin
				nw_en = 1'b1;
				pw_en = 1'b1;
				priority if (func_q == clrt_pkg::FN_REM_NEXT) begin
					nw_addr = sa_q;  nw_data = nn_q;
					pw_addr = snn_q; pw_data = a_q;
				end else begin
					pw_addr = sa_q;  pw_data = nn_q;
					nw_addr = snn_q; nw_data = a_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rd_addr = cmd.rd_head ? head_slot_q : slot_out;

	// Next link memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (nw_en) next_mem[nw_addr] <= nw_data;
		if (cmd.rd_en) rd_next_q <= next_mem[rd_addr];
	end

	// Prev link memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (pw_en) prev_mem[pw_addr] <= pw_data;
		if (cmd.rd_en) rd_prev_q <= prev_mem[rd_addr];
	end

	// Result register; a command on an empty ring returns zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) neighbour_q <= empty_q ? '0 : nb_q;
	end

	assign out_valid = out_valid_q;
	assign neighbour = neighbour_q;

	assign sts.is_load    = (func_q == clrt_pkg::FN_LOAD);
	assign sts.is_remove  = (func_q >= clrt_pkg::FN_REM_NEXT);
	assign sts.ring_empty = empty_q;
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule

`default_nettype wire

// File: rtl/clrt_ctrl.sv
// ----------------------------------------------------------------------------
// clrt_ctrl
// Sequencer of the ring table: steps each item through slot reduction,
// link reads, link writes and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module clrt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire clrt_pkg::sts_t sts,
	output clrt_pkg::cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_A    = 4'd1;
	localparam logic [3:0] ST_B    = 4'd2;
	localparam logic [3:0] ST_CA   = 4'd3;
	localparam logic [3:0] ST_CB   = 4'd4;
	localparam logic [3:0] ST_WN   = 4'd5;
	localparam logic [3:0] ST_CN   = 4'd6;
	localparam logic [3:0] ST_W1   = 4'd7;
	localparam logic [3:0] ST_W2   = 4'd8;
	localparam logic [3:0] ST_NN   = 4'd9;
	localparam logic [3:0] ST_WNN  = 4'd10;
	localparam logic [3:0] ST_CNN  = 4'd11;
	localparam logic [3:0] ST_WR   = 4'd12;
	localparam logic [3:0] ST_INIT = 4'd13;
	localparam logic [3:0] ST_RES  = 4'd14;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.slot_sel = clrt_pkg::SL_A;
		cmd.wr_step  = clrt_pkg::WR_NONE;
		unique case (state_q)
			ST_IDLE: begin
				cmd.cap_in = in_valid;
				if (in_valid) state_d = ST_A;
			end
			// Reduce the reference id; read the head for a load.
			ST_A: begin
				cmd.slot_sel = clrt_pkg::SL_A;
				cmd.rd_en    = 1'b1;
				cmd.rd_head  = 1'b1;
				state_d      = ST_B;
			end
			ST_B: begin
				cmd.slot_sel = clrt_pkg::SL_B;
				state_d      = ST_CA;
			end
			// Reference slot ready; commands on a non-empty ring read its links.
			ST_CA: begin
				cmd.cap_sa = 1'b1;
				cmd.rd_en  = !sts.ring_empty && !sts.is_load;
				priority if (sts.ring_empty && sts.is_load) begin
					state_d = ST_INIT;
				end else if (sts.ring_empty) begin
					state_d = ST_RES;
				end else begin
					state_d = ST_CB;
				end
			end
			// Pick the neighbour (or the tail for a load) and reduce it.
			ST_CB: begin
				cmd.cap_sb   = 1'b1;
				cmd.cap_nb   = 1'b1;
				cmd.slot_sel = clrt_pkg::SL_LINK;
				state_d      = ST_WN;
			end
			ST_WN: begin
				state_d = ST_CN;
			end
			ST_CN: begin
				cmd.cap_snb = 1'b1;
				cmd.rd_en   = sts.is_remove;
				state_d     = sts.is_remove ? ST_NN : ST_W1;
			end
			ST_W1: begin
				cmd.wr_step = clrt_pkg::WR_FIRST;
				state_d     = ST_W2;
			end
			ST_W2: begin
				cmd.wr_step = clrt_pkg::WR_SECOND;
				state_d     = sts.is_load ? ST_IDLE : ST_RES;
			end
			// Removal: fetch the entry beyond the removed one.
			ST_NN: begin
				cmd.cap_nn   = 1'b1;
				cmd.slot_sel = clrt_pkg::SL_LINK;
				state_d      = ST_WNN;
			end
			ST_WNN: begin
				state_d = ST_CNN;
			end
			ST_CNN: begin
				cmd.cap_snn = 1'b1;
				state_d     = ST_WR;
			end
			ST_WR: begin
				cmd.wr_step = clrt_pkg::WR_REMOVE;
				state_d     = ST_RES;
			end
			ST_INIT: begin
				cmd.wr_step  = clrt_pkg::WR_INIT;
				cmd.set_head = 1'b1;
				state_d      = ST_IDLE;
			end
			// Hand the result over once the output register is free.
			ST_RES: begin
				cmd.res_load = sts.out_free;
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
